// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion macros for the Ascii85 encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked at every rising edge outside reset.
`define A85_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define A85_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define A85_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define A85_ASSERT(label, clk, rst_n, prop, msg)
`define A85_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define A85_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hw/rtl/a85_pkg.sv -----
// ----------------------------------------------------------------------------
// Ascii85 encoder package
// Types, codes and character constants shared by the encoder modules.
// ----------------------------------------------------------------------------
package a85_pkg;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_DATA   = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_LINE_WIDTH = 2'd0,
    CFG_BEGIN_TAG  = 2'd1,
    CFG_END_TAG    = 2'd2
  } cfg_idx_e;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    JOB_START  = 2'd0,
    JOB_GROUP  = 2'd1,
    JOB_FINISH = 2'd2
  } job_kind_e;

  typedef enum logic [1:0] {
    CV_IDLE = 2'd0,
    CV_RUN  = 2'd1,
    CV_DONE = 2'd2
  } conv_state_e;

  typedef enum logic [3:0] {
    E_IDLE        = 4'd0,
    E_OPEN_LT     = 4'd1,
    E_OPEN_TILDE  = 4'd2,
    E_DIGIT       = 4'd3,
    E_WRAP        = 4'd4,
    E_FIN_WRAP    = 4'd5,
    E_CLOSE_TILDE = 4'd6,
    E_CLOSE_GT    = 4'd7,
    E_FIN_NL      = 4'd8
  } emit_state_e;

  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_Z     = 8'h7a;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_NL    = 8'h0a;

  localparam logic [7:0] LINE_WIDTH_RST = 8'd72;
  localparam logic [7:0] OPEN_TAG_POS   = 8'd2;

  // x / 85 == (x * RECIP_MULT) >> RECIP_SHIFT for every 32-bit x.
  localparam int unsigned RADIX       = 85;
  localparam logic [31:0] RECIP_MULT  = 32'hC0C0C0C1;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam logic [2:0]  NUM_DIGITS  = 3'd5;

  typedef struct packed {
    job_kind_e   kind;
    logic [31:0] word;
    logic [2:0]  ndig;
    logic        zero;
  } job_t;

  typedef struct packed {
    job_kind_e        kind;
    logic [2:0]       ndig;
    logic [4:0][7:0]  chars;
  } conv_job_t;

  typedef struct packed {
    logic [7:0] line_width;
    logic       begin_en;
    logic       end_en;
  } cfg_t;

endpackage

// ----- hw/rtl/a85_if.sv -----
// ----------------------------------------------------------------------------
// Ascii85 encoder channels
// Valid/ready interfaces for the input, output and configuration channels.
// ----------------------------------------------------------------------------
interface a85_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] data_byte;

  modport source (output valid, cmd, data_byte, input ready);
  modport sink   (input valid, cmd, data_byte, output ready);
endinterface

interface a85_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last;

  modport source (output valid, out_char, last, input ready);
  modport sink   (input valid, out_char, last, output ready);
endinterface

interface a85_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ascii85_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// Ascii85 stream encoder
// Top level: configuration registers, front, job queue, converter, emitter.
// ----------------------------------------------------------------------------
// The encoder takes one command word per cycle while its job queue of
// QUEUE_DEPTH entries has room, and gives at most one character per cycle.
// A full group is split into base-85 digits by one 32x32 reciprocal
// multiplier, one digit a cycle; the emitter takes a group while idle and
// then gives its characters and inserted newlines one after another.
// Conversion of one group overlaps emission of the one before. The last
// character of each command is flagged with last; start with the opening
// marker disabled, and data bytes inside a group, give no characters.
module ascii85_stream_encoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  a85_in_if.sink     in_i,
  a85_out_if.source  out_o,
  a85_cfg_if.sink    cfg_i
);

  a85_pkg::cfg_t      cfg_q;
  a85_pkg::job_t      push_job, pop_job;
  a85_pkg::conv_job_t conv_job;
  logic               push_valid, push_ready;
  logic               pop_valid, pop_ready;
  logic               conv_valid, conv_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_width <= a85_pkg::LINE_WIDTH_RST;
      cfg_q.begin_en   <= 1'b0;
      cfg_q.end_en     <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (a85_pkg::cfg_idx_e'(cfg_i.index))
        a85_pkg::CFG_LINE_WIDTH: cfg_q.line_width <= cfg_i.data;
        a85_pkg::CFG_BEGIN_TAG:  cfg_q.begin_en   <= cfg_i.data[0];
        a85_pkg::CFG_END_TAG:    cfg_q.end_en     <= cfg_i.data[0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  a85_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_job_o   (push_job)
  );

  a85_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_job_i   (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_job_o    (pop_job)
  );

  a85_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pop_valid),
    .in_ready_o  (pop_ready),
    .in_job_i    (pop_job),
    .out_valid_o (conv_valid),
    .out_ready_i (conv_ready),
    .out_job_o   (conv_job)
  );

  a85_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (conv_valid),
    .job_ready_o (conv_ready),
    .job_i       (conv_job),
    .out_o       (out_o)
  );

endmodule

// ----- hw/rtl/a85_fifo.sv -----
// ----------------------------------------------------------------------------
// Ascii85 job queue
// Small first-in first-out queue of jobs between the front and the converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module a85_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  a85_pkg::job_t   push_job_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output a85_pkg::job_t   pop_job_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  a85_pkg::job_t            mem_q [DEPTH];
  logic [PTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic                     push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop && !push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  `A85_ASSERT(a_fifo_count_range, clk_i, rst_ni, (count_q <= CNT_W'(DEPTH)), "queue overfilled")
  `A85_ASSERT_NXT(a_fifo_count_up, clk_i, rst_ni, push && !pop, count_q == $past(count_q) + CNT_W'(1), "queue count lost a word")

endmodule

// ----- hw/rtl/a85_front.sv -----
// ----------------------------------------------------------------------------
// Ascii85 front
// Accepts command words, packs data bytes into groups and queues jobs.
// ----------------------------------------------------------------------------
module a85_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  a85_in_if.sink          in_i,
  output logic            push_valid_o,
  input  logic            push_ready_i,
  output a85_pkg::job_t   push_job_o
);

  logic [31:0] group_q, group_d;
  logic [1:0]  byte_cnt_q, byte_cnt_d;
  logic [31:0] word_new;
  logic        accept;

  assign in_i.ready = push_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    // Bytes land big-endian: the first byte of a group is the top byte.
    word_new = group_q;
    word_new[{~byte_cnt_q, 3'b000} +: 8] = in_i.data_byte;

    group_d         = group_q;
    byte_cnt_d      = byte_cnt_q;
    push_valid_o    = 1'b0;
    push_job_o.kind = a85_pkg::JOB_START;
    push_job_o.word = group_q;
    push_job_o.ndig = 3'd0;
    push_job_o.zero = 1'b0;

    case (a85_pkg::cmd_e'(in_i.cmd))
      a85_pkg::CMD_START: begin
        push_valid_o = accept;
        if (accept) begin
          group_d    = '0;
          byte_cnt_d = '0;
        end
      end
      a85_pkg::CMD_DATA: begin
        push_job_o.kind = a85_pkg::JOB_GROUP;
        push_job_o.word = word_new;
        push_job_o.zero = (word_new == '0);
        push_job_o.ndig = (word_new == '0) ? 3'd1 : a85_pkg::NUM_DIGITS;
        push_valid_o    = accept && (byte_cnt_q == 2'd3);
        if (accept) begin
          if (byte_cnt_q == 2'd3) begin
            group_d    = '0;
            byte_cnt_d = '0;
          end else begin
            group_d    = word_new;
            byte_cnt_d = byte_cnt_q + 2'd1;
          end
        end
      end
      a85_pkg::CMD_FINISH: begin
        // A partial group of n bytes flushes as n+1 digits.
        push_job_o.kind = a85_pkg::JOB_FINISH;
        push_job_o.ndig = (byte_cnt_q == 2'd0) ? 3'd0 : {1'b0, byte_cnt_q} + 3'd1;
        push_valid_o    = accept;
        if (accept) begin
          group_d    = '0;
          byte_cnt_d = '0;
        end
      end
      default: begin
        push_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_q    <= '0;
      byte_cnt_q <= '0;
    end else begin
      group_q    <= group_d;
      byte_cnt_q <= byte_cnt_d;
    end
  end

endmodule

// ----- hw/rtl/a85_conv.sv -----
// ----------------------------------------------------------------------------
// Ascii85 digit converter
// Splits a 32-bit group into five base-85 digit characters, or a z for a zero group, one step a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module a85_conv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  a85_pkg::job_t       in_job_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output a85_pkg::conv_job_t  out_job_o
);

  a85_pkg::conv_state_e state_q, state_d;
  a85_pkg::conv_job_t   job_q, job_d;
  logic [2:0]           cnt_q, cnt_d;
  logic [31:0]          val_q, val_d;
  logic [31:0]          vprev_q;
  logic [63:0]          prod;
  logic [31:0]          quot;
  logic [31:0]          rem_full;
  logic [7:0]           digit_char;
  logic                 take;
  logic                 needs_conv;

  // val_q holds the previous quotient, vprev_q the dividend it came from,
  // so the remainder of one step is formed while the next one multiplies.
  assign prod       = 64'(val_q) * 64'(a85_pkg::RECIP_MULT);
  assign quot       = 32'(prod >> a85_pkg::RECIP_SHIFT);
  assign rem_full   = vprev_q - val_q * 32'(a85_pkg::RADIX);
  assign digit_char = {1'b0, rem_full[6:0]} + a85_pkg::CH_BANG;
  assign needs_conv = ((in_job_i.kind == a85_pkg::JOB_GROUP) && !in_job_i.zero) ||
                      ((in_job_i.kind == a85_pkg::JOB_FINISH) && (in_job_i.ndig != 3'd0));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      a85_pkg::CV_IDLE, a85_pkg::CV_DONE: begin
        if (take) begin
          if (in_valid_i) begin
            state_d = needs_conv ? a85_pkg::CV_RUN : a85_pkg::CV_DONE;
          end else begin
            state_d = a85_pkg::CV_IDLE;
          end
        end
      end
      a85_pkg::CV_RUN: begin
        if (cnt_q == a85_pkg::NUM_DIGITS) begin
          state_d = a85_pkg::CV_DONE;
        end
      end
      default: begin
        state_d = a85_pkg::CV_IDLE;
      end
    endcase
  end

  // Handshake outputs.
  always_comb begin
    out_valid_o = (state_q == a85_pkg::CV_DONE);
    take        = (state_q == a85_pkg::CV_IDLE) ||
                  ((state_q == a85_pkg::CV_DONE) && out_ready_i);
    in_ready_o  = take;
  end

  // Datapath.
  always_comb begin
    job_d = job_q;
    cnt_d = cnt_q;
    val_d = val_q;
    if (take && in_valid_i) begin
      job_d.kind = in_job_i.kind;
      job_d.ndig = in_job_i.ndig;
      if (in_job_i.zero) begin
        job_d.chars[0] = a85_pkg::CH_Z;
      end
      val_d = in_job_i.word;
      cnt_d = 3'd0;
    end else if (state_q == a85_pkg::CV_RUN) begin
      cnt_d = cnt_q + 3'd1;
      val_d = quot;
      if (cnt_q != 3'd0) begin
        job_d.chars[a85_pkg::NUM_DIGITS - cnt_q] = digit_char;
      end
    end
  end

  assign out_job_o = job_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= a85_pkg::CV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    val_q   <= val_d;
    vprev_q <= val_q;
  end

  `A85_ASSERT_IMP(a_conv_cnt_range, clk_i, rst_ni, state_q == a85_pkg::CV_RUN, cnt_q <= a85_pkg::NUM_DIGITS, "conversion step count out of range")
  `A85_ASSERT_IMP(a_conv_rem_range, clk_i, rst_ni, (state_q == a85_pkg::CV_RUN) && (cnt_q != 3'd0), rem_full < 32'(a85_pkg::RADIX), "base-85 remainder out of range")

endmodule

// ----- hw/rtl/a85_emit.sv -----
// ----------------------------------------------------------------------------
// Ascii85 character emitter
// Sequences tags, digits and newlines, tracks the line position and drives
// the registered output channel.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module a85_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  a85_pkg::cfg_t       cfg_i,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  a85_pkg::conv_job_t  job_i,
  a85_out_if.source           out_o
);

  a85_pkg::emit_state_e state_q, state_d;
  a85_pkg::conv_job_t   job_q, job_d;
  logic [2:0]           dig_idx_q, dig_idx_d;
  logic [7:0]           line_pos_q, line_pos_d;
  logic                 out_valid_q;
  logic [7:0]           out_char_q;
  logic                 out_last_q;

  logic       emit_valid;
  logic [7:0] emit_char;
  logic       emit_last;
  logic       out_free;
  logic       step;
  logic       job_take;
  logic       last_dig;
  logic       is_group;
  logic       wrap_now;
  logic       fin_wrap;

  assign out_free = !out_valid_q || out_o.ready;
  assign step     = !emit_valid || out_free;
  assign job_take = job_valid_i && job_ready_o;
  assign last_dig = (dig_idx_q == job_q.ndig - 3'd1);
  assign is_group = (job_q.kind == a85_pkg::JOB_GROUP);
  assign wrap_now = (line_pos_q >= cfg_i.line_width);
  // The closing marker must fit on the line, else it starts a new one.
  assign fin_wrap = ({1'b0, line_pos_q} + 9'd2) > {1'b0, cfg_i.line_width};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      a85_pkg::E_IDLE: begin
        if (job_take) begin
          case (job_i.kind)
            a85_pkg::JOB_START: begin
              state_d = cfg_i.begin_en ? a85_pkg::E_OPEN_LT : a85_pkg::E_IDLE;
            end
            a85_pkg::JOB_GROUP: begin
              state_d = a85_pkg::E_DIGIT;
            end
            a85_pkg::JOB_FINISH: begin
              state_d = (job_i.ndig != 3'd0) ? a85_pkg::E_DIGIT : a85_pkg::E_FIN_WRAP;
            end
            default: begin
              state_d = a85_pkg::E_IDLE;
            end
          endcase
        end
      end
      a85_pkg::E_OPEN_LT: begin
        if (step) state_d = a85_pkg::E_OPEN_TILDE;
      end
      a85_pkg::E_OPEN_TILDE: begin
        if (step) state_d = a85_pkg::E_IDLE;
      end
      a85_pkg::E_DIGIT: begin
        if (step) begin
          if (wrap_now) begin
            state_d = a85_pkg::E_WRAP;
          end else if (last_dig) begin
            state_d = is_group ? a85_pkg::E_IDLE : a85_pkg::E_FIN_WRAP;
          end
        end
      end
      a85_pkg::E_WRAP: begin
        if (step) begin
          if (last_dig) begin
            state_d = is_group ? a85_pkg::E_IDLE : a85_pkg::E_FIN_WRAP;
          end else begin
            state_d = a85_pkg::E_DIGIT;
          end
        end
      end
      a85_pkg::E_FIN_WRAP: begin
        if (step) state_d = cfg_i.end_en ? a85_pkg::E_CLOSE_TILDE : a85_pkg::E_FIN_NL;
      end
      a85_pkg::E_CLOSE_TILDE: begin
        if (step) state_d = a85_pkg::E_CLOSE_GT;
      end
      a85_pkg::E_CLOSE_GT: begin
        if (step) state_d = a85_pkg::E_FIN_NL;
      end
      a85_pkg::E_FIN_NL: begin
        if (step) state_d = a85_pkg::E_IDLE;
      end
      default: begin
        state_d = a85_pkg::E_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    emit_valid  = 1'b0;
    emit_char   = a85_pkg::CH_NL;
    emit_last   = 1'b0;
    job_ready_o = 1'b0;
    case (state_q)
      a85_pkg::E_IDLE: begin
        job_ready_o = 1'b1;
      end
      a85_pkg::E_OPEN_LT: begin
        emit_valid = 1'b1;
        emit_char  = a85_pkg::CH_LT;
      end
      a85_pkg::E_OPEN_TILDE: begin
        emit_valid = 1'b1;
        emit_char  = a85_pkg::CH_TILDE;
        emit_last  = 1'b1;
      end
      a85_pkg::E_DIGIT: begin
        emit_valid = 1'b1;
        emit_char  = job_q.chars[dig_idx_q];
        emit_last  = is_group && last_dig && !wrap_now;
      end
      a85_pkg::E_WRAP: begin
        emit_valid = 1'b1;
        emit_last  = is_group && last_dig;
      end
      a85_pkg::E_FIN_WRAP: begin
        emit_valid = fin_wrap;
      end
      a85_pkg::E_CLOSE_TILDE: begin
        emit_valid = 1'b1;
        emit_char  = a85_pkg::CH_TILDE;
      end
      a85_pkg::E_CLOSE_GT: begin
        emit_valid = 1'b1;
        emit_char  = a85_pkg::CH_GT;
      end
      a85_pkg::E_FIN_NL: begin
        emit_valid = 1'b1;
        emit_last  = 1'b1;
      end
      default: begin
        emit_valid = 1'b0;
      end
    endcase
  end

  // Job, digit index and line position.
  always_comb begin
    job_d      = job_q;
    dig_idx_d  = dig_idx_q;
    line_pos_d = line_pos_q;
    if (job_take) begin
      job_d     = job_i;
      dig_idx_d = 3'd0;
      if (job_i.kind == a85_pkg::JOB_START) begin
        line_pos_d = cfg_i.begin_en ? a85_pkg::OPEN_TAG_POS : 8'd0;
      end
    end else if (step) begin
      case (state_q)
        a85_pkg::E_DIGIT: begin
          if (wrap_now) begin
            line_pos_d = 8'd0;
          end else begin
            line_pos_d = line_pos_q + 8'd1;
            if (!last_dig) dig_idx_d = dig_idx_q + 3'd1;
          end
        end
        a85_pkg::E_WRAP: begin
          if (!last_dig) dig_idx_d = dig_idx_q + 3'd1;
        end
        a85_pkg::E_FIN_NL: begin
          line_pos_d = 8'd0;
        end
        default: begin
          line_pos_d = line_pos_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= a85_pkg::E_IDLE;
      dig_idx_q   <= '0;
      line_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      dig_idx_q  <= dig_idx_d;
      line_pos_q <= line_pos_d;
      if (out_free) begin
        out_valid_q <= emit_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (out_free) begin
      out_char_q <= emit_char;
      out_last_q <= emit_last;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.last     = out_last_q;

  `A85_ASSERT_IMP(a_emit_dig_idx, clk_i, rst_ni, (state_q == a85_pkg::E_DIGIT) || (state_q == a85_pkg::E_WRAP), dig_idx_q < job_q.ndig, "digit index past the group length")

endmodule

// ----- bench/a85_checker.sv -----
// ----------------------------------------------------------------------------
// Ascii85 encoder checker
// Watches the command, character and register channels of the encoder, keeps
// its own model of the encoder state and compares every character that leaves
// the block with the predicted text, in order, with its last flag.
// ----------------------------------------------------------------------------
module a85_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  a85_in_if           in_mon_i,
  a85_out_if          out_mon_i,
  a85_cfg_if          cfg_mon_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  import a85_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // Predicted text still on its way out of the block, oldest first.
  text_char_t  text_q[$];
  // Characters caused by the command word being predicted.
  logic [7:0]  word_chars_q[$];

  cfg_t        cfg_q;
  logic [31:0] group_q;
  logic [1:0]  count_q;
  logic [7:0]  pos_q;
  int unsigned n_err;
  text_char_t  want_c;

  function automatic void clear_stream();
    group_q = '0;
    count_q = '0;
    pos_q   = '0;
  endfunction

  // A character that counts toward the line position and may wrap the line.
  function automatic void put_counted(logic [7:0] ch);
    word_chars_q.push_back(ch);
    if (pos_q >= cfg_q.line_width) begin
      pos_q = '0;
      word_chars_q.push_back(CH_NL);
    end else begin
      pos_q = pos_q + 8'd1;
    end
  endfunction

  function automatic void put_digits(logic [31:0] grp, int ndig);
    logic [7:0]  digit [5];
    logic [31:0] rest;
    rest = grp;
    for (int i = 4; i >= 0; i--) begin
      digit[i] = 8'(rest % RADIX);
      rest     = rest / RADIX;
    end
    for (int i = 0; i < ndig; i++) put_counted(digit[i] + CH_BANG);
  endfunction

  function automatic void encode_word(logic [1:0] cmd, logic [7:0] data);
    word_chars_q.delete();
    case (cmd)
      CMD_START: begin
        clear_stream();
        if (cfg_q.begin_en) begin
          word_chars_q.push_back(CH_LT);
          word_chars_q.push_back(CH_TILDE);
          pos_q = OPEN_TAG_POS;
        end
      end
      CMD_DATA: begin
        group_q = group_q | ({24'd0, data} << {2'd3 - count_q, 3'd0});
        if (count_q == 2'd3) begin
          if (group_q == '0) put_counted(CH_Z);
          else put_digits(group_q, 5);
          group_q = '0;
          count_q = '0;
        end else begin
          count_q = count_q + 2'd1;
        end
      end
      CMD_FINISH: begin
        // A partial group keeps its zero low bytes and is never shortened to z.
        if (count_q != '0) put_digits(group_q, int'(count_q) + 1);
        if ({1'b0, pos_q} + 9'd2 > {1'b0, cfg_q.line_width}) word_chars_q.push_back(CH_NL);
        if (cfg_q.end_en) begin
          word_chars_q.push_back(CH_TILDE);
          word_chars_q.push_back(CH_GT);
        end
        word_chars_q.push_back(CH_NL);
        clear_stream();
      end
      default: ;
    endcase
    for (int i = 0; i < word_chars_q.size(); i++) begin
      text_q.push_back('{ch: word_chars_q[i], last: (i == word_chars_q.size() - 1)});
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q = '{line_width: LINE_WIDTH_RST, begin_en: 1'b0, end_en: 1'b0};
      clear_stream();
      text_q.delete();
      n_err     = 0;
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_mon_i.valid && cfg_mon_i.ready) begin
        case (cfg_mon_i.index)
          CFG_LINE_WIDTH: cfg_q.line_width = cfg_mon_i.data;
          CFG_BEGIN_TAG:  cfg_q.begin_en   = cfg_mon_i.data[0];
          CFG_END_TAG:    cfg_q.end_en     = cfg_mon_i.data[0];
          default: ;
        endcase
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        encode_word(in_mon_i.cmd, in_mon_i.data_byte);
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        if (text_q.size() == 0) begin
          if (n_err < 10) begin
            $display("a85_checker: unexpected char %h last %b", out_mon_i.out_char,
                     out_mon_i.last);
          end
          n_err++;
        end else begin
          want_c = text_q.pop_front();
          if (out_mon_i.out_char !== want_c.ch || out_mon_i.last !== want_c.last) begin
            if (n_err < 10) begin
              $display("a85_checker: expected char %h last %b, got char %h last %b",
                       want_c.ch, want_c.last, out_mon_i.out_char, out_mon_i.last);
            end
            n_err++;
          end
        end
      end
      pending_o <= text_q.size();
      errors_o  <= n_err;
    end
  end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Ascii85 encoder testbench
// Drives command words and register writes into the encoder with random
// gaps on both sides and one long output stall; a directed opening covers
// tags, zero groups, partial groups and a width lowered mid-line, then random
// streams run under a series of register settings. The checker beside the
// block predicts and compares every character.
// ----------------------------------------------------------------------------
module tb;
  import a85_pkg::*;

  localparam int unsigned IDLE_PCT      = 27;
  localparam int unsigned HOLD_LEN      = 300;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int unsigned RANDOM_WORDS  = 200;
  localparam int unsigned PHASE_WORDS   = 25;
  localparam logic [1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [1:0]  CFG_SPARE     = 2'd3;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        calm;
  logic        hold_req;
  int unsigned errors;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned counted;

  a85_in_if  in_w ();
  a85_out_if out_w ();
  a85_cfg_if cfg_w ();

  ascii85_stream_encoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w),
    .cfg_i  (cfg_w)
  );

  a85_checker i_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_mon_i  (in_w),
    .out_mon_i (out_w),
    .cfg_mon_i (cfg_w),
    .pending_o (pending),
    .errors_o  (errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Output side: random stalls, one long hold-off, none while calm.
  initial begin : rx_drive
    int unsigned hold_left;
    logic        hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_w.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni) begin
        out_w.ready <= 1'b0;
      end else if (hold_req && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_LEN;
        out_w.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_w.ready <= 1'b0;
      end else begin
        out_w.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Valid stays high from one word to the next unless a gap is drawn.
  task automatic send_word(logic [1:0] cmd, logic [7:0] data);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_w.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_w.valid     <= 1'b1;
    in_w.cmd       <= cmd;
    in_w.data_byte <= data;
    do @(posedge clk_i); while (!in_w.ready);
    if (cmd != CMD_UNUSED) counted++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    cfg_w.valid <= 1'b1;
    cfg_w.index <= idx;
    cfg_w.data  <= val;
    do @(posedge clk_i); while (!cfg_w.ready);
  endtask

  task automatic set_config(logic [7:0] width, logic begin_en, logic end_en, logic spare);
    write_reg(CFG_LINE_WIDTH, width);
    write_reg(CFG_BEGIN_TAG, {7'd0, begin_en});
    write_reg(CFG_END_TAG, {7'd0, end_en});
    if (spare) write_reg(CFG_SPARE, 8'($urandom));
    cfg_w.valid <= 1'b0;
  endtask

  // Let every predicted character drain, then give words that cause no
  // character time to pass through before the registers change.
  task automatic settle();
    in_w.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_bytes(int unsigned n);
    logic [7:0] b;
    logic       zero_grp;
    zero_grp = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 4 == 0) zero_grp = ($urandom_range(0, 99) < 15);
      if (zero_grp) begin
        b = 8'h00;
      end else begin
        case ($urandom_range(0, 9))
          0:       b = 8'h00;
          1:       b = 8'hff;
          default: b = 8'($urandom);
        endcase
      end
      send_word(CMD_DATA, b);
    end
  endtask

  // Mostly well-formed streams; some continue the open line without a start,
  // some stay open, and a few are plain noise including the unused code.
  task automatic send_stream();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      repeat ($urandom_range(1, 4)) send_word(2'($urandom_range(0, 3)), 8'($urandom));
    end else begin
      if (roll >= 25) send_word(CMD_START, 8'($urandom));
      if ($urandom_range(0, 99) < 8) send_bytes($urandom_range(16, 40));
      else send_bytes($urandom_range(0, 12));
      if ($urandom_range(0, 99) < 90) send_word(CMD_FINISH, 8'($urandom));
    end
  endtask

  initial begin : stim
    int unsigned phase;
    int unsigned phase_start;
    logic [7:0]  width;
    logic        begin_en;
    logic        end_en;

    rst_ni         <= 1'b0;
    in_w.valid     <= 1'b0;
    in_w.cmd       <= CMD_START;
    in_w.data_byte <= 8'h00;
    cfg_w.valid    <= 1'b0;
    cfg_w.index    <= CFG_LINE_WIDTH;
    cfg_w.data     <= 8'h00;
    calm           <= 1'b0;
    hold_req       <= 1'b0;
    counted = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Both tags, a short line, and a write to an index past the list.
    set_config(8'd10, 1'b1, 1'b1, 1'b1);
    send_word(CMD_START, 8'ha5);
    repeat (4) send_word(CMD_DATA, 8'h00);
    repeat (4) send_word(CMD_DATA, 8'hff);
    send_word(CMD_DATA, 8'h80);
    send_word(CMD_DATA, 8'h01);
    send_word(CMD_DATA, 8'h7f);
    send_word(CMD_DATA, 8'hfe);
    send_word(CMD_UNUSED, 8'h5a);
    // A partial group of one zero byte is flushed as digits.
    send_word(CMD_DATA, 8'h00);
    send_word(CMD_FINISH, 8'h3c);
    settle();

    // Leave a line open well past the width that follows.
    set_config(8'd255, 1'b0, 1'b0, 1'b0);
    send_word(CMD_START, 8'hc3);
    send_word(CMD_DATA, 8'h12);
    send_word(CMD_DATA, 8'h34);
    send_word(CMD_DATA, 8'h56);
    send_word(CMD_DATA, 8'h78);
    settle();
    set_config(8'd1, 1'b0, 1'b1, 1'b0);
    send_word(CMD_DATA, 8'h9a);
    send_word(CMD_DATA, 8'hbc);
    send_word(CMD_DATA, 8'hde);
    send_word(CMD_FINISH, 8'h0f);

    counted = 0;
    phase   = 0;
    while (counted < RANDOM_WORDS) begin
      settle();
      case (phase)
        0:       width = 8'd0;
        1:       width = 8'd255;
        2:       width = 8'd1;
        3:       width = LINE_WIDTH_RST;
        4:       width = 8'd2;
        default: width = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(3, 20));
      endcase
      begin_en = (phase < 4) ? phase[0] : 1'($urandom_range(0, 1));
      end_en   = (phase < 4) ? phase[1] : 1'($urandom_range(0, 1));
      set_config(width, begin_en, end_en, $urandom_range(0, 3) == 0);
      if (phase == 1) hold_req <= 1'b1;
      calm <= (phase == 3);
      phase_start = counted;
      while (counted < phase_start + PHASE_WORDS) send_stream();
      phase++;
    end
    settle();

    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/a85_pkg.sv
hw/rtl/a85_if.sv
hw/rtl/a85_fifo.sv
hw/rtl/a85_front.sv
hw/rtl/a85_conv.sv
hw/rtl/a85_emit.sv
hw/rtl/ascii85_stream_encoder.sv
bench/a85_checker.sv
bench/tb.sv
